### hw/rtl/mma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants for the matrix multiply-accumulate engine
// Item layouts, opcodes, register indexes and controller states.
// ----------------------------------------------------------------------------
package mma_pkg;

   localparam int MaxDim   = 8;
   localparam int DimW     = $clog2(MaxDim);
   localparam int Depth    = MaxDim * MaxDim;
   localparam int AddrW    = $clog2(Depth);
   localparam int CntW     = DimW + 1;

   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_LOAD_C  = 2'd2,
      OP_COMPUTE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_TRANS_A = 3'd0,
      REG_TRANS_B = 3'd1,
      REG_ROWS_M  = 3'd2,
      REG_COLS_N  = 3'd3,
      REG_DEPTH_K = 3'd4,
      REG_ALPHA   = 3'd5,
      REG_BETA    = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCALE,
      ST_SUM,
      ST_WRITE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]   opcode;
      logic [5:0]   elem_index;
      logic [31:0]  data_value;
   } req_type;

   typedef struct packed {
      logic [2:0]   out_row;
      logic [2:0]   out_col;
      logic [31:0]  out_value;
      logic         last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]   index;
      logic [15:0]  data;
   } csr_type;

   // geometry handed from the register block to the datapath
   typedef struct packed {
      logic            trans_a;
      logic            trans_b;
      logic [CntW-1:0] m;
      logic [CntW-1:0] n;
      logic [CntW-1:0] k;
      logic [15:0]     alpha;
      logic [15:0]     beta;
   } geom_type;

   function automatic logic [CntW-1:0] clamp_dim(input logic [3:0] v);
      logic [CntW-1:0] r;
      if (v == 4'd0) r = CntW'(1);
      else if (v > 4'(MaxDim)) r = CntW'(MaxDim);
      else r = CntW'(v);
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/matrix_multiply_accumulate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate: small fixed-point GEMM engine
// C = alpha*op(A)*op(B) + beta*C over three on-chip RAMs.
//
// channel  direction  payload
// req      in         opcode, elem_index, data_value
// rsp      out        out_row, out_col, out_value, last
// csr      in         register index, write data
//
// Loads are taken in idle and write their RAM word. A compute item walks the
// result elements in row-major order; for each element, ST_READ steps t from 0
// to k through RAM reads and the shared multiplier (one A*B product per cycle),
// then states SCALE, SUM, WRITE and EMIT scale, sum, write back and hand off.
// The rsp register decouples the walk; a stalled rsp holds the walk.
// Reset idles control, presets registers; RAM is undefined until loaded.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mma_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mma_pkg::rsp_type       rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire mma_pkg::csr_type  csr_data
);
   localparam int AW = mma_pkg::AddrW;
   localparam int CW = mma_pkg::CntW;

   mma_pkg::geom_type  geom;
   mma_pkg::state_type state_ff, state_in;

   logic [CW-1:0] i_ff, i_in, j_ff, j_in, t_ff, t_in;
   logic [47:0]   acc_ff, acc_in;
   logic signed [63:0] ta_ff, tb_ff;
   logic [31:0]   res_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   mma_pkg::rsp_type rsp_ff;

   logic [15:0] a_rd, b_rd;
   logic [31:0] c_rd;
   logic        a_we, b_we, c_we;
   logic [AW-1:0] a_ra, b_ra, c_ra, c_wa, ci;
   logic [31:0]   c_wd;
   logic          rd_live_ff;
   logic          accept;
   logic signed [31:0] prod;
   logic signed [15:0] sat16;
   logic signed [65:0] sum;

   mma_regs u_regs (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_data(csr_data), .geom(geom)
   );

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == mma_pkg::ST_IDLE);

   always_comb begin
      if ($signed(req_data.data_value) > 32'sd32767) sat16 = 16'sh7fff;
      else if ($signed(req_data.data_value) < -32'sd32768) sat16 = 16'sh8000;
      else sat16 = req_data.data_value[15:0];
   end

   // read addresses for step t of element (i,j)
   always_comb begin
      a_ra = geom.trans_a ? AW'(t_ff) * AW'(geom.m) + AW'(i_ff)
                          : AW'(i_ff) * AW'(geom.k) + AW'(t_ff);
      b_ra = geom.trans_b ? AW'(j_ff) * AW'(geom.k) + AW'(t_ff)
                          : AW'(t_ff) * AW'(geom.n) + AW'(j_ff);
      ci   = AW'(i_ff) * AW'(geom.n) + AW'(j_ff);
      c_ra = ci;
   end

   always_comb begin
      a_we = accept && req_data.opcode == mma_pkg::OP_LOAD_A;
      b_we = accept && req_data.opcode == mma_pkg::OP_LOAD_B;
      c_we = (accept && req_data.opcode == mma_pkg::OP_LOAD_C)
          || state_ff == mma_pkg::ST_WRITE;
      c_wa = (state_ff == mma_pkg::ST_WRITE) ? ci : req_data.elem_index;
      c_wd = (state_ff == mma_pkg::ST_WRITE) ? res_ff : req_data.data_value;
   end

   mma_ram #(.Width(16), .Depth(mma_pkg::Depth)) u_a (
      .clock(clock), .wr_en(a_we), .wr_addr(req_data.elem_index), .wr_data(sat16),
      .rd_addr(a_ra), .rd_data(a_rd));
   mma_ram #(.Width(16), .Depth(mma_pkg::Depth)) u_b (
      .clock(clock), .wr_en(b_we), .wr_addr(req_data.elem_index), .wr_data(sat16),
      .rd_addr(b_ra), .rd_data(b_rd));
   mma_ram #(.Width(32), .Depth(mma_pkg::Depth)) u_c (
      .clock(clock), .wr_en(c_we), .wr_addr(c_wa), .wr_data(c_wd),
      .rd_addr(c_ra), .rd_data(c_rd));

   assign prod = $signed(a_rd) * $signed(b_rd);
   assign sum  = 66'(ta_ff >>> 8) + 66'(tb_ff >>> 8);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mma_pkg::ST_IDLE:
            if (accept && req_data.opcode == mma_pkg::OP_COMPUTE) state_in = mma_pkg::ST_READ;
         mma_pkg::ST_READ:
            if (t_ff == geom.k) state_in = mma_pkg::ST_SCALE;
         mma_pkg::ST_SCALE: state_in = mma_pkg::ST_SUM;
         mma_pkg::ST_SUM:   state_in = mma_pkg::ST_WRITE;
         mma_pkg::ST_WRITE: state_in = mma_pkg::ST_EMIT;
         mma_pkg::ST_EMIT:
            if (!rsp_valid_ff || rsp_ready) begin
               if (i_ff == geom.m - CW'(1) && j_ff == geom.n - CW'(1))
                  state_in = mma_pkg::ST_IDLE;
               else
                  state_in = mma_pkg::ST_READ;
            end
         default: state_in = mma_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      t_in = t_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         mma_pkg::ST_IDLE: begin
            i_in = '0; j_in = '0; t_in = '0; acc_in = '0;
         end
         mma_pkg::ST_READ: begin
            t_in = t_ff + CW'(1);
            if (rd_live_ff) acc_in = acc_ff + 48'($signed(prod));
         end
         mma_pkg::ST_EMIT:
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               t_in = '0;
               acc_in = '0;
               if (j_ff == geom.n - CW'(1)) begin
                  j_in = '0;
                  i_in = i_ff + CW'(1);
               end else begin
                  j_in = j_ff + CW'(1);
               end
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mma_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_live_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_live_ff   <= (state_ff == mma_pkg::ST_READ) && (t_ff != geom.k);
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      t_ff <= t_in;
      acc_ff <= acc_in;
      if (state_ff == mma_pkg::ST_SCALE) begin
         ta_ff <= 64'($signed(acc_ff)) * 64'($signed(geom.alpha));
         tb_ff <= 64'($signed(c_rd)) * 64'($signed(geom.beta));
      end
      if (state_ff == mma_pkg::ST_SUM) begin
         if (sum > 66'sh7fffffff) res_ff <= 32'h7fffffff;
         else if (sum < -66'sh80000000) res_ff <= 32'h80000000;
         else res_ff <= sum[31:0];
      end
      if (state_ff == mma_pkg::ST_EMIT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff.out_row   <= i_ff[2:0];
         rsp_ff.out_col   <= j_ff[2:0];
         rsp_ff.out_value <= res_ff;
         rsp_ff.last      <= (i_ff == geom.m - CW'(1)) && (j_ff == geom.n - CW'(1));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == mma_pkg::ST_IDLE)
      else $error("ready outside idle");
   a_write_then_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == mma_pkg::ST_WRITE |=> state_ff == mma_pkg::ST_EMIT)
      else $error("write back not followed by emit");
   a_t_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == mma_pkg::ST_READ |-> t_ff <= geom.k)
      else $error("depth counter overrun");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result dropped under stall");
`endif
endmodule
`default_nettype wire

### hw/rtl/mma_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mma_ram: generic single-port-write, single-port-read RAM
// Read data is registered.
// ----------------------------------------------------------------------------
module mma_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### hw/rtl/mma_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mma_regs: configuration register file
// Holds transpose flags, dimensions and scales; presents clamped geometry.
// ----------------------------------------------------------------------------
module mma_regs (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire mma_pkg::csr_type  csr_data,
   output mma_pkg::geom_type      geom
);
   logic        trans_a_ff, trans_b_ff;
   logic [3:0]  rows_ff, cols_ff, depth_ff;
   logic [15:0] alpha_ff, beta_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_a_ff <= 1'b0;
         trans_b_ff <= 1'b0;
         rows_ff    <= 4'd8;
         cols_ff    <= 4'd8;
         depth_ff   <= 4'd8;
         alpha_ff   <= 16'd256;
         beta_ff    <= 16'd0;
      end else if (csr_valid) begin
         unique case (csr_data.index)
            mma_pkg::REG_TRANS_A: trans_a_ff <= csr_data.data[0];
            mma_pkg::REG_TRANS_B: trans_b_ff <= csr_data.data[0];
            mma_pkg::REG_ROWS_M:  rows_ff    <= csr_data.data[3:0];
            mma_pkg::REG_COLS_N:  cols_ff    <= csr_data.data[3:0];
            mma_pkg::REG_DEPTH_K: depth_ff   <= csr_data.data[3:0];
            mma_pkg::REG_ALPHA:   alpha_ff   <= csr_data.data;
            mma_pkg::REG_BETA:    beta_ff    <= csr_data.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      geom.trans_a = trans_a_ff;
      geom.trans_b = trans_b_ff;
      geom.m       = mma_pkg::clamp_dim(rows_ff);
      geom.n       = mma_pkg::clamp_dim(cols_ff);
      geom.k       = mma_pkg::clamp_dim(depth_ff);
      geom.alpha   = alpha_ff;
      geom.beta    = beta_ff;
   end
endmodule
`default_nettype wire
